// ===== hw/rtl/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// shared types and constants of the software timer table
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int SLOT_W      = 3;
    localparam int SLOT_EXT_W  = 7;
    localparam int CMD_W       = 3;
    localparam int KIND_W      = 2;
    localparam int STAT_W      = 8;
    localparam int TICKS_W     = 32;
    localparam int MAX_RESULTS = 8;
    localparam int EVC_W       = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CREATE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd5;

    localparam logic [KIND_W-1:0] KIND_EXPIRY = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACK    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_CREATE,
        OP_REMOVE,
        OP_WRITE,
        OP_CLEAR,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [SLOT_W-1:0]  slot;
        logic [TICKS_W-1:0] tmo;
        logic [STAT_W-1:0]  run;
        logic [STAT_W-1:0]  expst;
        logic [STAT_W-1:0]  sval;
    } cmd_entry_t;

endpackage

// ===== hw/rtl/stt_front.sv =====
// ----------------------------------------------------------------------------
// stt_front
// accepts commands, classifies them and queues them for the execution side
// ----------------------------------------------------------------------------
module stt_front
    import stt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [SLOT_W-1:0]   slot,
    input  logic [TICKS_W-1:0]  timeout_ticks,
    input  logic [STAT_W-1:0]   run_status,
    input  logic [STAT_W-1:0]   expiry_status,
    input  logic [STAT_W-1:0]   status_value,
    input  logic                pop,
    output logic                busy,
    output logic                q_valid,
    output cmd_entry_t          q_head
);

    cmd_entry_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                known;
    op_t                 op;
    logic                push;
    logic                do_pop;
    cmd_entry_t          new_entry;

    // unused codes are taken and dropped
    always_comb
    begin
        known = 1'b1;
        op    = OP_TICK;
        unique case (cmd)
            CMD_TICK:   op = OP_TICK;
            CMD_CREATE: op = OP_CREATE;
            CMD_REMOVE: op = OP_REMOVE;
            CMD_WRITE:  op = OP_WRITE;
            CMD_CLEAR:  op = OP_CLEAR;
            CMD_READ:   op = OP_READ;
            default:    known = 1'b0;
        endcase
    end

    assign busy    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_head  = entry_reg[rd_ptr_reg];
    assign push    = start && !busy && known;
    assign do_pop  = pop && q_valid;

    assign new_entry.op    = op;
    assign new_entry.slot  = slot;
    assign new_entry.tmo   = timeout_ticks;
    assign new_entry.run   = run_status;
    assign new_entry.expst = expiry_status;
    assign new_entry.sval  = status_value;

    assign wr_ptr_next = push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
    assign rd_ptr_next = do_pop ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
    assign count_next  = QCNT_W'(count_reg + QCNT_W'(push) - QCNT_W'(do_pop));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_entry;
        end
    end

endmodule

// ===== hw/rtl/stt_back.sv =====
// ----------------------------------------------------------------------------
// stt_back
// executes queued commands against the timer stores and issues results
// ----------------------------------------------------------------------------
module stt_back
    import stt_pkg::*;
#(
    parameter int NUM_TIMERS = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  cmd_entry_t          q_head,
    output logic                pop,
    output logic                result_valid,
    output logic [KIND_W-1:0]   kind,
    output logic [SLOT_W-1:0]   timer_slot,
    output logic                table_full,
    output logic [STAT_W-1:0]   status_read,
    output logic                last
);

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int UW = $clog2(NUM_TIMERS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_FLUSH,
        ST_READ
    } state_t;

    state_t                  state_reg, state_next;
    logic [UW-1:0]           walk_idx_reg, walk_idx_next;
    logic                    s1_v_reg, s1_v_next;
    logic [IW-1:0]           s1_idx_reg, s1_idx_next;
    logic                    pend_v_reg, pend_v_next;
    logic [SLOT_W-1:0]       pend_slot_reg, pend_slot_next;
    logic [EVC_W-1:0]        ev_cnt_reg, ev_cnt_next;
    logic [UW-1:0]           used_reg, used_next;
    logic [NUM_TIMERS-1:0]   valid_reg, valid_next;
    logic [NUM_TIMERS-1:0]   stwr_reg, stwr_next;
    logic [SLOT_W-1:0]       rd_slot_reg, rd_slot_next;
    logic                    rd_in_reg, rd_in_next;
    logic                    res_v_reg, res_v_next;
    logic [KIND_W-1:0]       kind_reg, kind_next;
    logic [SLOT_W-1:0]       tslot_reg, tslot_next;
    logic                    full_reg, full_next;
    logic [STAT_W-1:0]       stat_out_reg, stat_out_next;
    logic                    last_reg, last_next;

    logic [TICKS_W-1:0]      cnt_mem [NUM_TIMERS];
    logic [TICKS_W-1:0]      tmo_mem [NUM_TIMERS];
    logic [STAT_W-1:0]       run_mem [NUM_TIMERS];
    logic [STAT_W-1:0]       exp_mem [NUM_TIMERS];
    logic [STAT_W-1:0]       stat_mem [NUM_TIMERS];
    logic [TICKS_W-1:0]      cnt_rd_reg;
    logic [TICKS_W-1:0]      tmo_rd_reg;
    logic [STAT_W-1:0]       run_rd_reg;
    logic [STAT_W-1:0]       exp_rd_reg;
    logic [STAT_W-1:0]       stat_rd_reg;

    logic [IW-1:0]           rd_addr;
    logic                    cnt_we;
    logic [IW-1:0]           cnt_wa;
    logic [TICKS_W-1:0]      cnt_wd;
    logic                    stat_we;
    logic [IW-1:0]           stat_wa;
    logic [STAT_W-1:0]       stat_wd;
    logic                    cre_we;

    logic [SLOT_EXT_W-1:0]   slot_ext;
    logic [SLOT_EXT_W-1:0]   used_ext;
    logic [SLOT_EXT_W-1:0]   s1_ext;
    logic                    in_table;
    logic [IW-1:0]           slot_addr;
    logic [IW-1:0]           used_addr;
    logic                    hit;
    logic [TICKS_W-1:0]      inc;
    logic                    expire;

    assign slot_ext  = SLOT_EXT_W'(q_head.slot);
    assign used_ext  = SLOT_EXT_W'(used_reg);
    assign s1_ext    = SLOT_EXT_W'(s1_idx_reg);
    assign in_table  = (slot_ext < SLOT_EXT_W'(NUM_TIMERS));
    assign slot_addr = slot_ext[IW-1:0];
    assign used_addr = used_reg[IW-1:0];
    assign pop       = (state_reg == ST_IDLE) && q_valid;

    // per-slot compare and increment of the walk
    assign hit    = valid_reg[s1_idx_reg] && (stat_rd_reg == run_rd_reg);
    assign inc    = cnt_rd_reg + TICKS_W'(1);
    assign expire = hit && (inc == tmo_rd_reg);

    always_comb
    begin
        state_next     = state_reg;
        walk_idx_next  = walk_idx_reg;
        s1_v_next      = 1'b0;
        s1_idx_next    = s1_idx_reg;
        pend_v_next    = pend_v_reg;
        pend_slot_next = pend_slot_reg;
        ev_cnt_next    = ev_cnt_reg;
        used_next      = used_reg;
        valid_next     = valid_reg;
        stwr_next      = stwr_reg;
        rd_slot_next   = rd_slot_reg;
        rd_in_next     = rd_in_reg;
        res_v_next     = 1'b0;
        kind_next      = kind_reg;
        tslot_next     = tslot_reg;
        full_next      = 1'b0;
        stat_out_next  = '0;
        last_next      = 1'b0;
        cnt_we         = 1'b0;
        cnt_wa         = s1_idx_reg;
        cnt_wd         = inc;
        stat_we        = 1'b0;
        stat_wa        = s1_idx_reg;
        stat_wd        = exp_rd_reg;
        cre_we         = 1'b0;
        rd_addr        = (state_reg == ST_WALK) ? walk_idx_reg[IW-1:0] : slot_addr;

        // an event is held back until the next one shows whether it is the last
        if (s1_v_reg && hit)
        begin
            cnt_we = 1'b1;
            cnt_wd = expire ? '0 : inc;
            if (expire)
            begin
                stat_we = 1'b1;
                if (ev_cnt_reg < EVC_W'(MAX_RESULTS))
                begin
                    if (pend_v_reg)
                    begin
                        res_v_next = 1'b1;
                        kind_next  = KIND_EXPIRY;
                        tslot_next = pend_slot_reg;
                    end
                    pend_v_next    = 1'b1;
                    pend_slot_next = s1_ext[SLOT_W-1:0];
                    ev_cnt_next    = EVC_W'(ev_cnt_reg + 1'b1);
                end
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_head.op)
                        OP_TICK:
                        begin
                            walk_idx_next = '0;
                            ev_cnt_next   = '0;
                            pend_v_next   = 1'b0;
                            if (used_reg != '0)
                            begin
                                state_next = ST_WALK;
                            end
                        end
                        OP_CREATE:
                        begin
                            res_v_next = 1'b1;
                            kind_next  = KIND_ACK;
                            if (used_reg < UW'(NUM_TIMERS))
                            begin
                                cre_we                = 1'b1;
                                cnt_we                = 1'b1;
                                cnt_wa                = used_addr;
                                cnt_wd                = '0;
                                stat_we               = 1'b1;
                                stat_wa               = used_addr;
                                stat_wd               = q_head.sval;
                                valid_next[used_addr] = 1'b1;
                                stwr_next[used_addr]  = 1'b1;
                                used_next             = UW'(used_reg + 1'b1);
                                tslot_next            = used_ext[SLOT_W-1:0];
                            end
                            else
                            begin
                                full_next  = 1'b1;
                                tslot_next = '0;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (in_table)
                            begin
                                valid_next[slot_addr] = 1'b0;
                            end
                            res_v_next = 1'b1;
                            kind_next  = KIND_ACK;
                            tslot_next = q_head.slot;
                        end
                        OP_WRITE:
                        begin
                            if (in_table)
                            begin
                                stat_we              = 1'b1;
                                stat_wa              = slot_addr;
                                stat_wd              = q_head.sval;
                                stwr_next[slot_addr] = 1'b1;
                            end
                            res_v_next = 1'b1;
                            kind_next  = KIND_ACK;
                            tslot_next = q_head.slot;
                        end
                        OP_CLEAR:
                        begin
                            if (in_table)
                            begin
                                cnt_we = 1'b1;
                                cnt_wa = slot_addr;
                                cnt_wd = '0;
                            end
                            res_v_next = 1'b1;
                            kind_next  = KIND_ACK;
                            tslot_next = q_head.slot;
                        end
                        OP_READ:
                        begin
                            rd_slot_next = q_head.slot;
                            rd_in_next   = in_table && stwr_reg[slot_addr];
                            state_next   = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                s1_v_next     = 1'b1;
                s1_idx_next   = walk_idx_reg[IW-1:0];
                walk_idx_next = UW'(walk_idx_reg + 1'b1);
                if (UW'(walk_idx_reg + 1'b1) == used_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                if (pend_v_reg)
                begin
                    res_v_next = 1'b1;
                    kind_next  = KIND_EXPIRY;
                    tslot_next = pend_slot_reg;
                    last_next  = 1'b1;
                end
                pend_v_next = 1'b0;
                state_next  = ST_IDLE;
            end
            ST_READ:
            begin
                res_v_next    = 1'b1;
                kind_next     = KIND_STATUS;
                tslot_next    = rd_slot_reg;
                stat_out_next = rd_in_reg ? stat_rd_reg : '0;
                last_next     = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // acknowledges are always the only result of their command
        if (state_reg == ST_IDLE)
        begin
            last_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            walk_idx_reg  <= '0;
            s1_v_reg      <= 1'b0;
            s1_idx_reg    <= '0;
            pend_v_reg    <= 1'b0;
            pend_slot_reg <= '0;
            ev_cnt_reg    <= '0;
            used_reg      <= '0;
            valid_reg     <= '0;
            stwr_reg      <= '0;
            rd_slot_reg   <= '0;
            rd_in_reg     <= 1'b0;
            res_v_reg     <= 1'b0;
            kind_reg      <= '0;
            tslot_reg     <= '0;
            full_reg      <= 1'b0;
            stat_out_reg  <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            walk_idx_reg  <= walk_idx_next;
            s1_v_reg      <= s1_v_next;
            s1_idx_reg    <= s1_idx_next;
            pend_v_reg    <= pend_v_next;
            pend_slot_reg <= pend_slot_next;
            ev_cnt_reg    <= ev_cnt_next;
            used_reg      <= used_next;
            valid_reg     <= valid_next;
            stwr_reg      <= stwr_next;
            rd_slot_reg   <= rd_slot_next;
            rd_in_reg     <= rd_in_next;
            res_v_reg     <= res_v_next;
            kind_reg      <= kind_next;
            tslot_reg     <= tslot_next;
            full_reg      <= full_next;
            stat_out_reg  <= stat_out_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_rd_reg  <= cnt_mem[rd_addr];
        tmo_rd_reg  <= tmo_mem[rd_addr];
        run_rd_reg  <= run_mem[rd_addr];
        exp_rd_reg  <= exp_mem[rd_addr];
        stat_rd_reg <= stat_mem[rd_addr];
        if (cnt_we)
        begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        if (stat_we)
        begin
            stat_mem[stat_wa] <= stat_wd;
        end
        if (cre_we)
        begin
            tmo_mem[used_addr] <= q_head.tmo;
            run_mem[used_addr] <= q_head.run;
            exp_mem[used_addr] <= q_head.expst;
        end
    end

    assign result_valid = res_v_reg;
    assign kind         = kind_reg;
    assign timer_slot   = tslot_reg;
    assign table_full   = full_reg;
    assign status_read  = stat_out_reg;
    assign last         = last_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= UW'(NUM_TIMERS))
        else $error("slot allocation count beyond table size");

    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> walk_idx_reg < used_reg)
        else $error("walk index past allocated slots");

    a_pend_counted: assert property (@(posedge clk) disable iff (!rst_n)
        pend_v_reg |-> ev_cnt_reg != '0)
        else $error("held expiry event not counted");

    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |=> res_v_reg && kind_reg == KIND_STATUS && last_reg)
        else $error("status read did not produce its result");

endmodule

// ===== hw/rtl/software_timer_table.sv =====
// ----------------------------------------------------------------------------
// software_timer_table
// table of software timers with create, remove, write and read status, clear count and tick commands
//
// channel   direction  transfer when          fields
// command   in         start && !busy         cmd slot timeout_ticks run_status
//                                             expiry_status status_value
// result    out        result_valid           kind timer_slot table_full
//                                             status_read last
//
// create, remove, write status and clear count execute in the idle state of
// the execution side, read status passes through a read state, and a tick
// walks the created slots one slot per cycle through the timer stores, then
// drains and flushes (no walk when no slot was created).
// a two-entry command queue decouples intake from execution: busy is high
// only while the queue is full.
// results are one-cycle strobes and cannot be held off; reset clears control
// state and valid bits only, the stores are not swept.
// ----------------------------------------------------------------------------
module software_timer_table
    import stt_pkg::*;
#(
    parameter int NUM_TIMERS = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [SLOT_W-1:0]   slot,
    input  logic [TICKS_W-1:0]  timeout_ticks,
    input  logic [STAT_W-1:0]   run_status,
    input  logic [STAT_W-1:0]   expiry_status,
    input  logic [STAT_W-1:0]   status_value,
    output logic                result_valid,
    output logic [KIND_W-1:0]   kind,
    output logic [SLOT_W-1:0]   timer_slot,
    output logic                table_full,
    output logic [STAT_W-1:0]   status_read,
    output logic                last
);

    logic       q_valid;
    logic       pop;
    cmd_entry_t q_head;

    stt_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .cmd           (cmd),
        .slot          (slot),
        .timeout_ticks (timeout_ticks),
        .run_status    (run_status),
        .expiry_status (expiry_status),
        .status_value  (status_value),
        .pop           (pop),
        .busy          (busy),
        .q_valid       (q_valid),
        .q_head        (q_head)
    );

    stt_back #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .pop          (pop),
        .result_valid (result_valid),
        .kind         (kind),
        .timer_slot   (timer_slot),
        .table_full   (table_full),
        .status_read  (status_read),
        .last         (last)
    );

endmodule
